// File: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Expects aclk and aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mac_cpu_pkg.sv
// Package for the microcoded accumulator CPU: widths, opcodes, controller
// states, command/status structs and the memory address fold. No dependencies.
package mac_cpu_pkg;

    localparam int unsigned MEM_WORDS_DEF   = 4096;
    localparam int unsigned SCREEN_SIDE_DEF = 64;
    localparam int unsigned ADDR_W          = 12;
    localparam int unsigned DATA_W          = 16;
    localparam int unsigned COORD_W         = 6;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_LODA  = 4'd1,
        OP_LODB  = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_OUT   = 4'd5,
        OP_JMP   = 4'd6,
        OP_STA   = 4'd7,
        OP_LDI   = 4'd8,
        OP_JMPZ  = 4'd9,
        OP_JMPC  = 4'd10,
        OP_HLT   = 4'd11,
        OP_LDAIN = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr_write;
        logic load_write;
        logic fetch;
        logic decode;
        logic execute;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic halted;
        logic clear_last;
    } status_t;

    // addr mod words for words >= 256: four restoring subtract steps
    function automatic logic [ADDR_W-1:0] mod_words(input logic [ADDR_W-1:0] addr,
                                                    input int unsigned words);
        logic [16:0] r;
        logic [16:0] m;
        r = {5'b0, addr};
        for (int i = 3; i >= 0; i--) begin
            m = 17'(words << i);
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage

// File: sv/mac_cpu_ctrl.sv
// Sequencer for the microcoded accumulator CPU: state machine, handshakes.
// Depends on mac_cpu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mac_cpu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_action,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  mac_cpu_pkg::status_t status,
    output mac_cpu_pkg::cmd_t    cmd
);
    import mac_cpu_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (!s_action) begin
                        state_next = ST_WRITE;
                    end else if (status.halted) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WRITE: begin
                cmd.load_write = 1'b1;
                state_next     = ST_DONE;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_NEXT(a_load_shows, cmd.out_load, m_valid_reg, "result beat not presented")
    `ASSERT_NEXT(a_step_fetch, s_valid && s_ready && s_action && !status.halted,
                 state_reg == ST_FETCH, "running step did not fetch")
    `ASSERT_NEXT(a_exec_done, state_reg == ST_EXEC, state_reg == ST_DONE,
                 "execute not followed by completion")
    `ASSERT_NEXT(a_done_holds, state_reg == ST_DONE && m_valid_reg && !m_ready,
                 state_reg == ST_DONE, "result overwritten while stalled")

endmodule

// File: sv/mac_cpu_dp.sv
// Datapath for the microcoded accumulator CPU: program memory, registers,
// ALU, raster counters and result register. Depends on mac_cpu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mac_cpu_dp #(
    parameter int unsigned MEM_WORDS   = mac_cpu_pkg::MEM_WORDS_DEF,
    parameter int unsigned SCREEN_SIDE = mac_cpu_pkg::SCREEN_SIDE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mac_cpu_pkg::cmd_t                   cmd,
    output mac_cpu_pkg::status_t                status,
    input  logic [mac_cpu_pkg::ADDR_W-1:0]      s_load_address,
    input  logic [mac_cpu_pkg::DATA_W-1:0]      s_load_data,
    output logic [mac_cpu_pkg::ADDR_W-1:0]      m_program_counter,
    output logic [mac_cpu_pkg::DATA_W-1:0]      m_acc_a,
    output logic [mac_cpu_pkg::DATA_W-1:0]      m_reg_b,
    output logic                                m_zero_flag,
    output logic                                m_carry_flag,
    output logic                                m_halted,
    output logic                                m_pixel_valid,
    output logic [mac_cpu_pkg::DATA_W-1:0]      m_pixel_value,
    output logic [mac_cpu_pkg::COORD_W-1:0]     m_pixel_x,
    output logic [mac_cpu_pkg::COORD_W-1:0]     m_pixel_y
);
    import mac_cpu_pkg::*;

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam int unsigned XW = ($clog2(SCREEN_SIDE) > COORD_W) ? $clog2(SCREEN_SIDE)
                                                                 : COORD_W;

    logic [DATA_W-1:0] mem [MEM_WORDS];

    logic [DATA_W-1:0]  rdata_reg;
    logic [DATA_W-1:0]  ir_reg, ir_next;
    logic [ADDR_W-1:0]  pc_reg, pc_next;
    logic [DATA_W-1:0]  a_reg, a_next;
    logic [DATA_W-1:0]  b_reg, b_next;
    logic               z_reg, z_next;
    logic               c_reg, c_next;
    logic               halt_reg, halt_next;
    logic [DATA_W-1:0]  ow_reg, ow_next;
    logic [XW-1:0]      rx_reg, rx_next;
    logic [XW-1:0]      ry_reg, ry_next;
    logic               pix_reg, pix_next;
    logic [COORD_W-1:0] px_reg, px_next;
    logic [COORD_W-1:0] py_reg, py_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]  ld_addr_reg;
    logic [DATA_W-1:0]  ld_data_reg;

    op_t               dec_op, ex_op;
    logic [ADDR_W-1:0] rd_src, wr_src;
    logic [AW-1:0]     raddr, waddr;
    logic [DATA_W-1:0] wdata;
    logic              mem_we, mem_re;
    logic [DATA_W:0]   alu_res;

    assign dec_op = op_t'(rdata_reg[DATA_W-1:ADDR_W]);
    assign ex_op  = op_t'(ir_reg[DATA_W-1:ADDR_W]);

    // memory port control
    always_comb begin
        if (cmd.fetch) begin
            rd_src = pc_reg;
        end else if (dec_op == OP_LDAIN) begin
            rd_src = a_reg[ADDR_W-1:0];
        end else begin
            rd_src = rdata_reg[ADDR_W-1:0];
        end
        raddr  = AW'(mod_words(rd_src, MEM_WORDS));
        mem_re = cmd.fetch || cmd.decode;

        wr_src = cmd.load_write ? ld_addr_reg : rdata_reg[ADDR_W-1:0];
        mem_we = 1'b0;
        waddr  = AW'(mod_words(wr_src, MEM_WORDS));
        wdata  = a_reg;
        if (cmd.clr_write) begin
            mem_we = 1'b1;
            waddr  = clr_cnt_reg;
            wdata  = '0;
        end else if (cmd.load_write) begin
            mem_we = 1'b1;
            wdata  = ld_data_reg;
        end else if (cmd.decode && dec_op == OP_STA) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign alu_res = (ex_op == OP_SUB) ? ({1'b0, a_reg} - {1'b0, rdata_reg})
                                       : ({1'b0, a_reg} + {1'b0, rdata_reg});

    always_comb begin
        ir_next      = ir_reg;
        pc_next      = pc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        z_next       = z_reg;
        c_next       = c_reg;
        halt_next    = halt_reg;
        ow_next      = ow_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        pix_next     = pix_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        clr_cnt_next = clr_cnt_reg;

        if (cmd.clr_write) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.capture) begin
            pix_next = 1'b0;
            px_next  = '0;
            py_next  = '0;
        end
        if (cmd.fetch) begin
            pc_next = pc_reg + 1'b1;
        end
        if (cmd.decode) begin
            ir_next = rdata_reg;
        end
        if (cmd.execute) begin
            case (ex_op)
                OP_LODA, OP_LDAIN: a_next = rdata_reg;
                OP_LODB:           b_next = rdata_reg;
                OP_ADD, OP_SUB: begin
                    b_next = rdata_reg;
                    a_next = alu_res[DATA_W-1:0];
                    z_next = (alu_res[DATA_W-1:0] == '0);
                    c_next = (ex_op == OP_SUB) ? !alu_res[DATA_W] : alu_res[DATA_W];
                end
                OP_OUT: begin
                    ow_next  = a_reg;
                    pix_next = 1'b1;
                    px_next  = rx_reg[COORD_W-1:0];
                    py_next  = ry_reg[COORD_W-1:0];
                    if (rx_reg == XW'(SCREEN_SIDE - 1)) begin
                        rx_next = '0;
                        ry_next = (ry_reg == XW'(SCREEN_SIDE - 1)) ? '0 : ry_reg + 1'b1;
                    end else begin
                        rx_next = rx_reg + 1'b1;
                    end
                end
                OP_JMP:  pc_next = ir_reg[ADDR_W-1:0];
                OP_LDI:  a_next  = {{(DATA_W-ADDR_W){1'b0}}, ir_reg[ADDR_W-1:0]};
                OP_JMPZ: if (z_reg) pc_next = ir_reg[ADDR_W-1:0];
                OP_JMPC: if (c_reg) pc_next = ir_reg[ADDR_W-1:0];
                OP_HLT:  halt_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_reg      <= '0;
            pc_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            z_reg       <= 1'b0;
            c_reg       <= 1'b0;
            halt_reg    <= 1'b0;
            ow_reg      <= '0;
            rx_reg      <= '0;
            ry_reg      <= '0;
            pix_reg     <= 1'b0;
            px_reg      <= '0;
            py_reg      <= '0;
            clr_cnt_reg <= '0;
        end else begin
            ir_reg      <= ir_next;
            pc_reg      <= pc_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            z_reg       <= z_next;
            c_reg       <= c_next;
            halt_reg    <= halt_next;
            ow_reg      <= ow_next;
            rx_reg      <= rx_next;
            ry_reg      <= ry_next;
            pix_reg     <= pix_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // input beat and result registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ld_addr_reg <= s_load_address;
            ld_data_reg <= s_load_data;
        end
        if (cmd.out_load) begin
            m_program_counter <= pc_reg;
            m_acc_a           <= a_reg;
            m_reg_b           <= b_reg;
            m_zero_flag       <= z_reg;
            m_carry_flag      <= c_reg;
            m_halted          <= halt_reg;
            m_pixel_valid     <= pix_reg;
            m_pixel_value     <= ow_reg;
            m_pixel_x         <= px_reg;
            m_pixel_y         <= py_reg;
        end
    end

    assign status.halted     = halt_reg;
    assign status.clear_last = (clr_cnt_reg == AW'(MEM_WORDS - 1));

    `ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt cleared without reset")
    `ASSERT_NEXT(a_pc_quiet, !cmd.fetch && !cmd.execute, $stable(pc_reg),
                 "pc moved outside fetch or execute")

endmodule

// File: sv/microcoded_accumulator_cpu.sv
// Top level of the microcoded accumulator CPU: sequencer plus datapath.
// Depends on mac_cpu_pkg, mac_cpu_ctrl and mac_cpu_dp.
//
//   channel  dir  handshake         payload
//   s_       in   s_valid/s_ready   action, load_address, load_data
//   m_       out  m_valid/m_ready   pc, A, B, flags, halted, pixel fields
//
// Load beat: accept, write, result. Step beat: accept, fetch read, decode with
// operand read or store, execute, result. Halted step: accept, result.
// After reset the program memory is cleared while s_ready is held low.
// A result waiting on m_ready stalls only the completion of the next beat.
module microcoded_accumulator_cpu #(
    parameter int unsigned MEM_WORDS   = mac_cpu_pkg::MEM_WORDS_DEF,
    parameter int unsigned SCREEN_SIDE = mac_cpu_pkg::SCREEN_SIDE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [mac_cpu_pkg::ADDR_W-1:0]  s_load_address,
    input  logic [mac_cpu_pkg::DATA_W-1:0]  s_load_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mac_cpu_pkg::ADDR_W-1:0]  m_program_counter,
    output logic [mac_cpu_pkg::DATA_W-1:0]  m_acc_a,
    output logic [mac_cpu_pkg::DATA_W-1:0]  m_reg_b,
    output logic                            m_zero_flag,
    output logic                            m_carry_flag,
    output logic                            m_halted,
    output logic                            m_pixel_valid,
    output logic [mac_cpu_pkg::DATA_W-1:0]  m_pixel_value,
    output logic [mac_cpu_pkg::COORD_W-1:0] m_pixel_x,
    output logic [mac_cpu_pkg::COORD_W-1:0] m_pixel_y
);
    import mac_cpu_pkg::*;

    cmd_t    cmd;
    status_t status;

    mac_cpu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mac_cpu_dp #(
        .MEM_WORDS   (MEM_WORDS),
        .SCREEN_SIDE (SCREEN_SIDE)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_load_address    (s_load_address),
        .s_load_data       (s_load_data),
        .m_program_counter (m_program_counter),
        .m_acc_a           (m_acc_a),
        .m_reg_b           (m_reg_b),
        .m_zero_flag       (m_zero_flag),
        .m_carry_flag      (m_carry_flag),
        .m_halted          (m_halted),
        .m_pixel_valid     (m_pixel_valid),
        .m_pixel_value     (m_pixel_value),
        .m_pixel_x         (m_pixel_x),
        .m_pixel_y         (m_pixel_y)
    );

endmodule
